// ===== hw/rtl/olist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, request and status codes, and controller states for the
// ordered list block.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned LCNT_W   = 8;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  // common width for comparing a count against a position
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DEDUP  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DD_NEXT,
    S_DD_CAND,
    S_DD_CMP,
    S_DD_KEEP,
    S_QRY,
    S_DONE
  } state_e;

endpackage

// ===== hw/rtl/olist_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of an address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ordered_list_insert_dedup_minmax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_dedup_minmax
// Ordered list of signed 32-bit values kept in one RAM, with clear, insert,
// deduplicate and max/min/length query requests.
// ----------------------------------------------------------------------------
// One request is taken at a time and answers with one word. All list entries
// sit in a single RAM with one read and one write port and registered read
// data, so requests walk the stored entries through that port. An accepted
// insert shifts the entries from the insert position to the end up by one,
// a query on a non-empty list reads every entry, and deduplicate compares
// each entry against the kept ones, one RAM read per compare. The result
// word sits in an output register; a new request is taken once the previous
// one has finished, even while its result still waits to be taken.
// ----------------------------------------------------------------------------
module ordered_list_insert_dedup_minmax (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [olist_pkg::POS_W-1:0] position_i,
  input  logic signed [olist_pkg::DATA_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        removed_any_o,
  output logic signed [olist_pkg::DATA_W-1:0] max_value_o,
  output logic signed [olist_pkg::DATA_W-1:0] min_value_o,
  output logic [olist_pkg::LCNT_W-1:0] list_count_o
);

  import olist_pkg::*;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          j_q, j_d;
  logic [CNT_W-1:0]          kept_q, kept_d;
  logic                      rv_q, rv_d;
  logic [ADDR_W-1:0]         wa_q, wa_d;
  logic                      first_q, first_d;
  logic [DATA_W-1:0]         cand_q, cand_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [DATA_W-1:0]         val_q, val_d;
  status_e                   res_status_q, res_status_d;
  logic                      res_removed_q, res_removed_d;
  logic signed [DATA_W-1:0]  res_max_q, res_max_d;
  logic signed [DATA_W-1:0]  res_min_q, res_min_d;
  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic                      out_removed_q, out_removed_d;
  logic signed [DATA_W-1:0]  out_max_q, out_max_d;
  logic signed [DATA_W-1:0]  out_min_q, out_min_d;
  logic [LCNT_W-1:0]         out_count_q, out_count_d;

  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;

  logic [CMP_W-1:0]          count_wide, idx_wide, pos_wide, in_pos_wide, pos_m1;
  logic [CNT_W-1:0]          idx_dec, j_inc;
  logic                      in_fire;

  olist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_wide  = CMP_W'(count_q);
  assign idx_wide    = CMP_W'(idx_q);
  assign pos_wide    = CMP_W'(pos_q);
  assign in_pos_wide = CMP_W'(position_i);
  assign pos_m1      = pos_wide - CMP_W'(1);
  assign idx_dec     = idx_q - CNT_W'(1);
  assign j_inc       = j_q + CNT_W'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    j_d           = j_q;
    kept_d        = kept_q;
    rv_d          = 1'b0;
    wa_d          = wa_q;
    first_d       = first_q;
    cand_d        = cand_q;
    pos_d         = pos_q;
    val_d         = val_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    res_max_d     = res_max_q;
    res_min_d     = res_min_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_max_d     = out_max_q;
    out_min_d     = out_min_q;
    out_count_d   = out_count_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pos_d         = position_i;
          val_d         = value_i;
          res_status_d  = ST_OK;
          res_removed_d = 1'b0;
          res_max_d     = '0;
          res_min_d     = '0;
          case (req_e'(req_type_i))
            REQ_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            REQ_INSERT: begin
              // position check comes before the full check
              if ((in_pos_wide == '0) || (in_pos_wide > count_wide + CMP_W'(1))) begin
                res_status_d = ST_BAD_POS;
                state_d      = S_DONE;
              end else if (count_wide >= CMP_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else begin
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            REQ_DEDUP: begin
              idx_d   = '0;
              kept_d  = '0;
              state_d = S_DD_NEXT;
            end
            REQ_QUERY: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                idx_d   = '0;
                first_d = 1'b1;
                state_d = S_QRY;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_INS: begin
        // read entry k-1 now, write it to k next cycle
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (idx_wide >= pos_wide) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[ADDR_W-1:0];
          wa_d      = idx_q[ADDR_W-1:0];
          idx_d     = idx_dec;
          rv_d      = 1'b1;
        end else if (!rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_m1[ADDR_W-1:0];
          ram_wdata = val_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = S_DONE;
        end
      end

      S_DD_NEXT: begin
        if (idx_q == count_q) begin
          res_removed_d = (kept_q != count_q);
          count_d       = kept_q;
          state_d       = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
          state_d   = S_DD_CAND;
        end
      end

      S_DD_CAND: begin
        cand_d = ram_rdata;
        if (kept_q == '0) begin
          state_d = S_DD_KEEP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          j_d       = '0;
          state_d   = S_DD_CMP;
        end
      end

      S_DD_CMP: begin
        if (ram_rdata == cand_q) begin
          // drop the repeat
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_DD_NEXT;
        end else if (j_inc == kept_q) begin
          state_d = S_DD_KEEP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_inc[ADDR_W-1:0];
          j_d       = j_inc;
        end
      end

      S_DD_KEEP: begin
        ram_we    = 1'b1;
        ram_waddr = kept_q[ADDR_W-1:0];
        ram_wdata = cand_q;
        kept_d    = kept_q + CNT_W'(1);
        idx_d     = idx_q + CNT_W'(1);
        state_d   = S_DD_NEXT;
      end

      S_QRY: begin
        if (rv_q) begin
          if (first_q) begin
            res_max_d = ram_rdata;
            res_min_d = ram_rdata;
            first_d   = 1'b0;
          end else if ($signed(ram_rdata) > res_max_q) begin
            res_max_d = ram_rdata;
          end else if ($signed(ram_rdata) < res_min_q) begin
            res_min_d = ram_rdata;
          end
        end
        if (idx_q != count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
          idx_d     = idx_q + CNT_W'(1);
          rv_d      = 1'b1;
        end else if (!rv_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_removed_d = res_removed_q;
          out_max_d     = res_max_q;
          out_min_d     = res_min_q;
          out_count_d   = count_wide[LCNT_W-1:0];
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    j_q           <= j_d;
    kept_q        <= kept_d;
    wa_q          <= wa_d;
    first_q       <= first_d;
    cand_q        <= cand_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    res_max_q     <= res_max_d;
    res_min_q     <= res_min_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_max_q     <= out_max_d;
    out_min_q     <= out_min_d;
    out_count_q   <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign removed_any_o = out_removed_q;
  assign max_value_o   = out_max_q;
  assign min_value_o   = out_min_q;
  assign list_count_o  = out_count_q;

endmodule

// ===== hw/rtl/olist_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_chk
// Port-level checks for the ordered list block, bound to the top level.
// ----------------------------------------------------------------------------
module olist_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  req_type_i,
  input logic [olist_pkg::POS_W-1:0] position_i,
  input logic signed [olist_pkg::DATA_W-1:0] value_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic                        removed_any_o,
  input logic signed [olist_pkg::DATA_W-1:0] max_value_o,
  input logic signed [olist_pkg::DATA_W-1:0] min_value_o,
  input logic [olist_pkg::LCNT_W-1:0] list_count_o
);

  import olist_pkg::*;

  // a stalled request word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(req_type_i) && $stable(position_i) && $stable(value_i))
    else $error("request word changed while stalled");

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // only a clean deduplicate reports removals
  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_any_o |-> status_o == ST_OK)
    else $error("removal flagged on a failed request");

  // an empty query reports zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      list_count_o == '0 && max_value_o == '0 && min_value_o == '0)
    else $error("empty query with nonzero fields");

  // max never below min
  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_value_o >= min_value_o)
    else $error("max below min");

endmodule

bind ordered_list_insert_dedup_minmax olist_chk u_olist_chk (.*);
